// ===== sv/vnr_pkg.sv =====
// ----------------------------------------------------------------------------
// vnr_pkg
// Word types, request codes and sequencer states for the vertex normal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vnr_pkg;

  localparam int IDX_W    = 10;
  localparam int IN_POS_W = 24;
  localparam int NRM_W    = 16;
  localparam int SUM_W    = 32;
  localparam int QT_W     = 15;
  localparam int NUM_W    = 45;
  localparam int SQ_W     = 63;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_TRI  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  typedef struct packed {
    logic [1:0]                  req_type;
    logic [IDX_W-1:0]            vertex_index;
    logic [IDX_W-1:0]            second_index;
    logic [IDX_W-1:0]            third_index;
    logic signed [IN_POS_W-1:0]  pos_x;
    logic signed [IN_POS_W-1:0]  pos_y;
    logic signed [IN_POS_W-1:0]  pos_z;
  } vnr_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         read_vertex;
    logic signed [NRM_W-1:0]  normal_x;
    logic signed [NRM_W-1:0]  normal_y;
    logic signed [NRM_W-1:0]  normal_z;
  } vnr_out_t;

  typedef enum logic [13:0] {
    ST_CLEAR      = 14'b00000000000001,
    ST_IDLE       = 14'b00000000000010,
    ST_POS_RD     = 14'b00000000000100,
    ST_MUL_CROSS  = 14'b00000000001000,
    ST_SUM_RD     = 14'b00000000010000,
    ST_SUM_LD     = 14'b00000000100000,
    ST_NORM_MAG   = 14'b00000001000000,
    ST_NORM_SHIFT = 14'b00000010000000,
    ST_MUL_SQ     = 14'b00000100000000,
    ST_SQRT       = 14'b00001000000000,
    ST_DIV_INIT   = 14'b00010000000000,
    ST_DIV        = 14'b00100000000000,
    ST_ACC_RD     = 14'b01000000000000,
    ST_ACC_WR     = 14'b10000000000000
  } vnr_state_t;

endpackage

`default_nettype wire

// ===== sv/vertex_normal_recompute.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_recompute
// Smooth vertex normals: position store, saturating normal accumulators and
// a shared multiplier / square root / divider sequence for normalization.
//
//   channel | signals                    | handshake
//   input   | start, busy, in_word       | taken when start & !busy
//   result  | out_valid, out_word        | one-cycle strobe, no stall
//
// a load is written at acceptance and busy stays low; the time a triangle or a read
// takes is set by the one-bit-per-cycle square root (32 steps), the restoring divider
// (run once per component) and the one-place shifter (up to 29 places);
// a zero vector skips normalization
// after reset the accumulators are cleared, with busy high
// reset is synchronous, active low; the receiver cannot stall results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_normal_recompute #(
  parameter int VERTEX_COUNT  = 1024,
  parameter int POSITION_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire vnr_pkg::vnr_in_t   in_word,
  output logic                    out_valid,
  output vnr_pkg::vnr_out_t       out_word
);
  import vnr_pkg::*;

  localparam int AW  = $clog2(VERTEX_COUNT);
  localparam int PB  = POSITION_BITS;
  localparam int DW  = PB + 1;
  localparam int CW  = 2 * DW + 1;
  localparam int VW  = (CW > SUM_W + 1) ? CW : SUM_W + 1;
  localparam int OW  = (DW > 31) ? DW : 31;
  localparam int PW  = 2 * OW;
  localparam logic [31:0] RECIP = 32'((64'd1 << 20) / VERTEX_COUNT);

  function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] idx);
    logic [31:0] prod;
    logic [31:0] q;
    logic [31:0] r;
    prod = 32'(idx) * RECIP;
    q    = prod >> 20;
    r    = 32'(idx) - q * 32'(VERTEX_COUNT);
    if (r >= 32'(VERTEX_COUNT)) r = r - 32'(VERTEX_COUNT);
    return r[AW-1:0];
  endfunction

  function automatic logic [PB-1:0] fit_pos(input logic signed [IN_POS_W-1:0] p);
    logic signed [63:0] e;
    e = 64'(p);
    return e[PB-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                               input logic signed [NRM_W-1:0] n);
    logic signed [SUM_W:0] t;
    t = (SUM_W + 1)'(s) + (SUM_W + 1)'(n);
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

  // storage
  logic [3*PB-1:0]    pos_mem [VERTEX_COUNT];
  logic [3*SUM_W-1:0] sum_mem [VERTEX_COUNT];
  logic [3*PB-1:0]    pos_q;
  logic [3*SUM_W-1:0] sum_q;

  logic               pos_we;
  logic [AW-1:0]      pos_raddr;
  logic               sum_we;
  logic [AW-1:0]      sum_waddr;
  logic [AW-1:0]      sum_raddr;
  logic [3*SUM_W-1:0] sum_wdata;

  // control
  vnr_state_t         state_r;
  logic [AW-1:0]      clr_r;
  logic [4:0]         cnt_r;
  logic [1:0]         ci_r;
  logic               is_tri_r;
  logic               out_valid_r;
  vnr_out_t           out_word_r;

  // datapath
  logic [AW-1:0]            a_r, b_r, c_r;
  logic [IDX_W-1:0]         echo_r;
  logic signed [DW-1:0]     pb_r [3];
  logic signed [DW-1:0]     pc_r [3];
  logic signed [DW-1:0]     u_r  [3];
  logic signed [DW-1:0]     w_r  [3];
  logic signed [VW-1:0]     vec_r [3];
  logic [VW-1:0]            mag_r [3];
  logic [2:0]               sgn_r;
  logic [VW-1:0]            m_r;
  logic signed [PW-1:0]     prod_r;
  logic [SQ_W-2:0]          sq_r;
  logic [SQ_W-1:0]          sv_r, sres_r, sbit_r;
  logic [30:0]              r_r;
  logic [NUM_W-1:0]         rem_r, dsh_r;
  logic [QT_W-1:0]          qt_r;
  logic signed [NRM_W-1:0]  nrm_r [3];

  logic                     accept;
  logic signed [DW-1:0]     pos_s [3];
  logic signed [OW-1:0]     mul_a, mul_b;
  logic [VW-1:0]            vabs [3];
  logic [VW-1:0]            vmax;
  logic [SQ_W-1:0]          s_t;
  logic                     s_ge;
  logic [SQ_W-1:0]          sres_nxt;
  logic                     d_ge;
  logic [QT_W-1:0]          qt_nxt;
  logic [AW-1:0]            acc_idx;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_s[i] = DW'($signed(pos_q[i*PB +: PB]));
      vabs[i]  = vec_r[i][VW-1] ? VW'(-vec_r[i]) : VW'(vec_r[i]);
    end
    vmax = vabs[0];
    if (vabs[1] > vmax) vmax = vabs[1];
    if (vabs[2] > vmax) vmax = vabs[2];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_MUL_SQ) begin
      mul_a = OW'($signed({1'b0, mag_r[cnt_r[2:1]][29:0]}));
      mul_b = mul_a;
    end else begin
      case (cnt_r[3:1])
        3'd0: begin mul_a = OW'(u_r[1]); mul_b = OW'(w_r[2]); end
        3'd1: begin mul_a = OW'(u_r[2]); mul_b = OW'(w_r[1]); end
        3'd2: begin mul_a = OW'(u_r[2]); mul_b = OW'(w_r[0]); end
        3'd3: begin mul_a = OW'(u_r[0]); mul_b = OW'(w_r[2]); end
        3'd4: begin mul_a = OW'(u_r[0]); mul_b = OW'(w_r[1]); end
        3'd5: begin mul_a = OW'(u_r[1]); mul_b = OW'(w_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // square root and divider steps
  always_comb begin
    s_t      = sres_r + sbit_r;
    s_ge     = (sv_r >= s_t);
    sres_nxt = s_ge ? ((sres_r >> 1) + sbit_r) : (sres_r >> 1);
    d_ge     = (rem_r >= dsh_r);
    qt_nxt   = {qt_r[QT_W-2:0], d_ge};
  end

  always_comb begin
    case (ci_r)
      2'd0:    acc_idx = a_r;
      2'd1:    acc_idx = b_r;
      default: acc_idx = c_r;
    endcase
  end

  // memory ports
  always_comb begin
    pos_we    = accept && (in_word.req_type == REQ_LOAD);
    case (cnt_r[1:0])
      2'd0:    pos_raddr = b_r;
      2'd1:    pos_raddr = c_r;
      default: pos_raddr = a_r;
    endcase
    sum_raddr = (state_r == ST_ACC_RD) ? acc_idx : a_r;
    sum_we    = 1'b0;
    sum_waddr = wrap_idx(in_word.vertex_index);
    sum_wdata = '0;
    if (state_r == ST_CLEAR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_r;
    end else if (state_r == ST_ACC_WR) begin
      sum_we    = 1'b1;
      sum_waddr = acc_idx;
      for (int i = 0; i < 3; i++) begin
        sum_wdata[i*SUM_W +: SUM_W] = sat_add($signed(sum_q[i*SUM_W +: SUM_W]), nrm_r[i]);
      end
    end else if (pos_we) begin
      sum_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[wrap_idx(in_word.vertex_index)] <=
        {fit_pos(in_word.pos_z), fit_pos(in_word.pos_y), fit_pos(in_word.pos_x)};
    end
    pos_q <= pos_mem[pos_raddr];
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_q <= sum_mem[sum_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      ci_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(VERTEX_COUNT - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            a_r      <= wrap_idx(in_word.vertex_index);
            b_r      <= wrap_idx(in_word.second_index);
            c_r      <= wrap_idx(in_word.third_index);
            echo_r   <= in_word.vertex_index;
            is_tri_r <= (in_word.req_type == REQ_TRI);
            cnt_r    <= '0;
            if (in_word.req_type == REQ_TRI) state_r <= ST_POS_RD;
            else if (in_word.req_type == REQ_READ) state_r <= ST_SUM_RD;
          end
        end
        ST_POS_RD: begin
          cnt_r <= cnt_r + 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (cnt_r == 5'd1) pb_r[i] <= pos_s[i];
            if (cnt_r == 5'd2) begin
              u_r[i]  <= pb_r[i] - pos_s[i];
              pc_r[i] <= pos_s[i];
            end
            if (cnt_r == 5'd3) begin
              w_r[i]   <= pc_r[i] - pos_s[i];
              vec_r[i] <= '0;
            end
          end
          if (cnt_r == 5'd3) begin
            cnt_r   <= '0;
            state_r <= ST_MUL_CROSS;
          end
        end
        ST_MUL_CROSS: begin
          cnt_r <= cnt_r + 1'b1;
          if (!cnt_r[0]) begin
            prod_r <= mul_a * mul_b;
          end else begin
            if (cnt_r[1]) vec_r[cnt_r[3:2]] <= vec_r[cnt_r[3:2]] - VW'(prod_r);
            else          vec_r[cnt_r[3:2]] <= vec_r[cnt_r[3:2]] + VW'(prod_r);
          end
          if (cnt_r == 5'd11) state_r <= ST_NORM_MAG;
        end
        ST_SUM_RD: state_r <= ST_SUM_LD;
        ST_SUM_LD: begin
          for (int i = 0; i < 3; i++) begin
            vec_r[i] <= VW'($signed(sum_q[i*SUM_W +: SUM_W]));
          end
          state_r <= ST_NORM_MAG;
        end
        ST_NORM_MAG: begin
          for (int i = 0; i < 3; i++) begin
            sgn_r[i] <= vec_r[i][VW-1];
            mag_r[i] <= vabs[i];
          end
          m_r     <= vmax;
          state_r <= ST_NORM_SHIFT;
        end
        ST_NORM_SHIFT: begin
          cnt_r <= '0;
          sq_r  <= '0;
          if (m_r == '0) begin
            for (int i = 0; i < 3; i++) nrm_r[i] <= '0;
            ci_r <= '0;
            if (is_tri_r) begin
              state_r <= ST_ACC_RD;
            end else begin
              out_valid_r <= 1'b1;
              out_word_r  <= '{read_vertex: echo_r, normal_x: '0, normal_y: '0,
                               normal_z: '0};
              state_r     <= ST_IDLE;
            end
          end else if (m_r[VW-1:30] != '0) begin
            m_r <= m_r >> 1;
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (!m_r[29]) begin
            m_r <= m_r << 1;
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            state_r <= ST_MUL_SQ;
          end
        end
        ST_MUL_SQ: begin
          cnt_r <= cnt_r + 1'b1;
          if (!cnt_r[0]) begin
            prod_r <= mul_a * mul_b;
          end else begin
            sq_r <= sq_r + prod_r[SQ_W-2:0];
          end
          if (cnt_r == 5'd5) begin
            sv_r    <= {1'b0, sq_r + prod_r[SQ_W-2:0]};
            sres_r  <= '0;
            sbit_r  <= {1'b1, {(SQ_W - 1){1'b0}}};
            cnt_r   <= '0;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (s_ge) sv_r <= sv_r - s_t;
          sres_r <= sres_nxt;
          sbit_r <= sbit_r >> 2;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == 5'd31) begin
            r_r     <= sres_nxt[30:0];
            ci_r    <= '0;
            state_r <= ST_DIV_INIT;
          end
        end
        ST_DIV_INIT: begin
          rem_r   <= NUM_W'({mag_r[ci_r][29:0], 14'd0}) + NUM_W'(r_r >> 1);
          dsh_r   <= NUM_W'({r_r, 14'd0});
          qt_r    <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (d_ge) rem_r <= rem_r - dsh_r;
          dsh_r <= dsh_r >> 1;
          qt_r  <= qt_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(QT_W - 1)) begin
            nrm_r[ci_r] <= sgn_r[ci_r] ? -NRM_W'(qt_nxt) : NRM_W'(qt_nxt);
            if (ci_r == 2'd2) begin
              ci_r <= '0;
              if (is_tri_r) begin
                state_r <= ST_ACC_RD;
              end else begin
                out_valid_r <= 1'b1;
                out_word_r  <= '{read_vertex: echo_r, normal_x: nrm_r[0],
                                 normal_y: nrm_r[1],
                                 normal_z: sgn_r[2] ? -NRM_W'(qt_nxt) : NRM_W'(qt_nxt)};
                state_r     <= ST_IDLE;
              end
            end else begin
              ci_r    <= ci_r + 1'b1;
              state_r <= ST_DIV_INIT;
            end
          end
        end
        ST_ACC_RD: state_r <= ST_ACC_WR;
        ST_ACC_WR: begin
          if (ci_r == 2'd2) begin
            ci_r    <= '0;
            state_r <= ST_IDLE;
          end else begin
            ci_r    <= ci_r + 1'b1;
            state_r <= ST_ACC_RD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
